FILE: hw/rtl/mcs_pkg.sv
// Shared types and constants for the motor command slew and PWM block.
`timescale 1ns / 1ps

package mcs_pkg;

  typedef struct packed {
    logic signed [15:0] speed_command;
    logic        [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic signed [7:0] applied_speed;
    logic              forward_drive;
    logic              reverse_drive;
    logic        [7:0] duty;
  } out_t;

  typedef struct packed {
    logic [6:0] deadband;
    logic [6:0] ramp_per_period;
    logic [7:0] min_duty;
  } cfg_t;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int MUL_W      = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RAMP     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_DUTY = 2'd2;

  localparam logic [6:0] DEADBAND_RST = 7'd10;
  localparam logic [6:0] RAMP_RST     = 7'd5;
  localparam logic [7:0] MIN_DUTY_RST = 8'd40;

  localparam logic signed [15:0] CMD_HI = 16'sd100;
  localparam logic signed [15:0] CMD_LO = -16'sd100;

  // ramp*elapsed/20 exceeds the cap once the product reaches 201*20
  localparam logic [31:0] SAT_PRODUCT = 32'd4020;
  localparam logic [7:0]  STEP_CAP    = 8'd200;
  localparam logic [8:0]  DUTY_MAX    = 9'd255;

  // floor(x/20) = (x*3277)>>16 for x < 4020
  localparam logic [MUL_W-1:0] RECIP_20 = 16'd3277;
  localparam int               SHIFT_20 = 16;
  // floor(x/99) = (x*21184)>>21 for x < 32768
  localparam logic [MUL_W-1:0] RECIP_99 = 16'd21184;
  localparam int               SHIFT_99 = 21;

endpackage

FILE: hw/rtl/motor_command_slew_pwm.sv
// Top level: configuration registers, request handshake and result register.
`timescale 1ns / 1ps

// Motor command shaper. Each request carries a signed speed command and a
// millisecond timestamp; the command is clamped to +/-100, zeroed inside the
// deadband, slew limited against the last applied speed by
// max(1, min(200, ramp*elapsed/20)) and mapped to direction lines and a PWM
// duty. From acceptance to a valid result, one shared 16x16 multiplier is
// used four times in sequence (ramp*elapsed, the reciprocal divide by 20, the
// duty scale, the reciprocal divide by 99), with a step for the slew compare
// between the two pairs and a final step that hands the result to the output
// register. in_ready is high only while the sequencer is idle, so a new
// request is not accepted until the previous one has been handed off.
// A finished result sits in the output register so the next request can be
// taken while it waits; if that register is still full when the sequencer
// finishes, the sequencer holds in its hand-off step and in_ready stays low
// until the receiver drains it. Configuration writes take effect at once and
// should be made while no request is in flight; writes to index 3 are ignored.
module motor_command_slew_pwm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mcs_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mcs_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [mcs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [mcs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import mcs_pkg::*;

  cfg_t  cfg_r;
  logic  out_valid_r;
  out_t  out_data_r;
  logic  core_idle;
  logic  res_valid;
  logic  res_take;
  out_t  res;
  logic  start;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband        <= DEADBAND_RST;
      cfg_r.ramp_per_period <= RAMP_RST;
      cfg_r.min_duty        <= MIN_DUTY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DEADBAND: cfg_r.deadband        <= cfg_wdata[6:0];
        REG_RAMP:     cfg_r.ramp_per_period <= cfg_wdata[6:0];
        REG_MIN_DUTY: cfg_r.min_duty        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = core_idle;
  assign start    = in_valid && core_idle;

  // result register frees up when empty or being drained this cycle
  assign res_take = !out_valid_r || out_ready;

  mcs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (start),
    .req       (in_data),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/mcs_mul.sv
// Shared 16x16 unsigned multiplier with registered product.
`timescale 1ns / 1ps

module mcs_mul (
  input  logic                        clk,
  input  logic                        load,
  input  logic [mcs_pkg::MUL_W-1:0]   op_a,
  input  logic [mcs_pkg::MUL_W-1:0]   op_b,
  output logic [2*mcs_pkg::MUL_W-1:0] prod_r
);
  import mcs_pkg::*;

  logic [2*MUL_W-1:0] prod_nxt;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

FILE: hw/rtl/mcs_core.sv
// Sequencer and datapath: deadband, slew limit and duty mapping.
`timescale 1ns / 1ps

module mcs_core (
  input  logic          clk,
  input  logic          rst_n,
  input  mcs_pkg::cfg_t cfg,
  input  logic          start,
  input  mcs_pkg::in_t  req,
  output logic          idle,
  output logic          res_valid,
  input  logic          res_take,
  output mcs_pkg::out_t res
);
  import mcs_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LIM   = 3'd1;
  localparam logic [2:0] ST_DIV20 = 3'd2;
  localparam logic [2:0] ST_SLEW  = 3'd3;
  localparam logic [2:0] ST_DMUL  = 3'd4;
  localparam logic [2:0] ST_DDIV  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic signed [7:0] last_speed_r, last_speed_nxt;
  logic [31:0]       last_time_r;
  logic signed [7:0] target_r, target_nxt;
  logic [11:0]       elapsed_r;
  logic              sat_r, sat_nxt;

  logic              mul_load;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [2*MUL_W-1:0] prod_r;

  logic [31:0]       diff, elapsed;
  logic signed [15:0] clamped;
  logic signed [8:0] c9, db9;
  logic [7:0]        lim, step;
  logic signed [8:0] last9, delta9, step9, new9;
  logic [7:0]        mag;
  logic [6:0]        dmag;
  logic [7:0]        quot;
  logic [8:0]        sum9;

  mcs_mul u_mul (
    .clk    (clk),
    .load   (mul_load),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  // request front end: clamp, deadband, elapsed time
  always_comb begin
    if (req.speed_command > CMD_HI) begin
      clamped = CMD_HI;
    end else if (req.speed_command < CMD_LO) begin
      clamped = CMD_LO;
    end else begin
      clamped = req.speed_command;
    end
    c9  = clamped[8:0];
    db9 = $signed({2'b00, cfg.deadband});
    if (c9 > -db9 && c9 < db9) begin
      target_nxt = 8'sd0;
    end else begin
      target_nxt = c9[7:0];
    end
    diff    = req.time_ms - last_time_r;
    elapsed = (diff == 32'd0) ? 32'd1 : diff;
  end

  // slew step
  always_comb begin
    lim    = sat_r ? STEP_CAP : prod_r[SHIFT_20+7:SHIFT_20];
    step   = (lim == 8'd0) ? 8'd1 : lim;
    step9  = $signed({1'b0, step});
    last9  = {last_speed_r[7], last_speed_r};
    delta9 = {target_r[7], target_r} - last9;
    if (delta9 > step9) begin
      delta9 = step9;
    end else if (delta9 < -step9) begin
      delta9 = -step9;
    end
    new9 = last9 + delta9;
  end

  // duty magnitude and final value
  always_comb begin
    mag  = last_speed_r[7] ? 8'(-last_speed_r) : 8'(last_speed_r);
    dmag = (mag == 8'd0) ? 7'd0 : 7'(mag - 8'd1);
    quot = prod_r[SHIFT_99+7:SHIFT_99];
    sum9 = {1'b0, quot} + {1'b0, cfg.min_duty};
    res.applied_speed = last_speed_r;
    res.forward_drive = (last_speed_r > 8'sd0);
    res.reverse_drive = (last_speed_r < 8'sd0);
    if (last_speed_r == 8'sd0) begin
      res.duty = 8'd0;
    end else if (sum9 > DUTY_MAX) begin
      res.duty = DUTY_MAX[7:0];
    end else begin
      res.duty = sum9[7:0];
    end
  end

  // sequencer and multiplier operand select
  always_comb begin
    state_nxt      = state_r;
    last_speed_nxt = last_speed_r;
    sat_nxt        = sat_r;
    mul_load       = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // a zero ramp keeps the product at zero however long the gap
          sat_nxt   = (elapsed >= SAT_PRODUCT) && (cfg.ramp_per_period != 7'd0);
          state_nxt = ST_LIM;
        end
      end
      ST_LIM: begin
        mul_load  = 1'b1;
        mul_a     = {4'd0, elapsed_r};
        mul_b     = {9'd0, cfg.ramp_per_period};
        state_nxt = ST_DIV20;
      end
      ST_DIV20: begin
        mul_load  = 1'b1;
        mul_a     = {4'd0, prod_r[11:0]};
        mul_b     = RECIP_20;
        sat_nxt   = sat_r | (prod_r >= SAT_PRODUCT);
        state_nxt = ST_SLEW;
      end
      ST_SLEW: begin
        last_speed_nxt = new9[7:0];
        state_nxt      = ST_DMUL;
      end
      ST_DMUL: begin
        mul_load  = 1'b1;
        mul_a     = {9'd0, dmag};
        mul_b     = {8'd0, 8'(DUTY_MAX[7:0] - cfg.min_duty)};
        state_nxt = ST_DDIV;
      end
      ST_DDIV: begin
        mul_load  = 1'b1;
        mul_a     = prod_r[MUL_W-1:0];
        mul_b     = RECIP_99;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_speed_r <= 8'sd0;
      last_time_r  <= 32'd0;
      sat_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_speed_r <= last_speed_nxt;
      sat_r        <= sat_nxt;
      if (start && state_r == ST_IDLE) begin
        last_time_r <= req.time_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && state_r == ST_IDLE) begin
      target_r  <= target_nxt;
      elapsed_r <= elapsed[11:0];
    end
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_FIN);

  a_start_goes_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (start && state_r == ST_IDLE) |=> (state_r == ST_LIM))
    else $error("accepted request did not enter limit step");

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SLEW) |=> (last_speed_r <= 8'sd100 && last_speed_r >= -8'sd100))
    else $error("applied speed out of range");

  a_fin_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && res_take) |=> (state_r == ST_IDLE))
    else $error("result handed off but sequencer not idle");

  a_speed_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SLEW) |=> $stable(last_speed_r))
    else $error("last speed changed outside slew step");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the motor command slew and PWM block.
`timescale 1ns / 1ps

module testbench;
  import mcs_pkg::*;

  // Run bounds. The limit leaves ample room for every request, even with the
  // receiver idling most of the time and one long receiver hold-off.
  localparam int RUN_LIMIT         = 400000;
  localparam int ITEMS_PER_SETTING = 128;
  localparam int RX_HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES     = 20;

  // Shaping constants
  localparam int SPEED_LIMIT = 100;
  localparam int STEP_MAX    = 200;
  localparam int PERIOD_MS   = 20;
  localparam int DUTY_TOP    = 255;

  // Index past the register list; writes there are dropped
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_ADDR_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]   reg_val;
    in_t                     req;
    bit                      pinned;
    out_t                    result;
  } plan_row_t;

  typedef struct {
    bit   pinned;
    out_t result;
  } pin_entry_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  motor_command_slew_pwm i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the block's registers and state
  logic [6:0]  deadband_m  = DEADBAND_RST;
  logic [6:0]  ramp_m      = RAMP_RST;
  logic [7:0]  min_duty_m  = MIN_DUTY_RST;
  int          last_speed_m = 0;
  logic [31:0] last_stamp_m = '0;

  out_t        expected_drive_q[$];
  pin_entry_t  pinned_drive_q[$];
  plan_row_t   directed_plan[$];

  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          tx_idle_pct    = 0;
  int          rx_idle_pct    = 0;
  bit          rx_hold_req    = 1'b0;
  logic [31:0] ms_clock       = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicted drive outputs for one accepted request; advances the shadow
  // speed and timestamp exactly as the block does.
  function automatic out_t shape_command(input in_t req);
    int                target;
    int                step;
    int                delta;
    int                mag;
    int                duty;
    logic [31:0]       elapsed;
    longint unsigned   lim;
    out_t              res;
    target = int'(req.speed_command);
    if (target > SPEED_LIMIT) target = SPEED_LIMIT;
    if (target < -SPEED_LIMIT) target = -SPEED_LIMIT;
    // deadband above 100 swallows every command
    if (target > -int'(deadband_m) && target < int'(deadband_m)) target = 0;

    // elapsed wraps mod 2^32; a repeated stamp counts as 1 ms
    elapsed = req.time_ms - last_stamp_m;
    last_stamp_m = req.time_ms;
    if (elapsed == 32'd0) elapsed = 32'd1;
    lim = (64'(ramp_m) * 64'(elapsed)) / 64'(PERIOD_MS);
    if (lim > 64'(STEP_MAX)) lim = 64'(STEP_MAX);
    step = int'(lim);
    if (step < 1) step = 1;       // also covers a zero ramp

    delta = target - last_speed_m;
    if (delta > step) delta = step;
    else if (delta < -step) delta = -step;
    last_speed_m = last_speed_m + delta;

    if (last_speed_m == 0) begin
      duty = 0;
    end else begin
      mag  = (last_speed_m < 0) ? -last_speed_m : last_speed_m;
      duty = (mag - 1) * (DUTY_TOP - int'(min_duty_m)) / 99 + int'(min_duty_m);
      if (duty > DUTY_TOP) duty = DUTY_TOP;
      if (duty < 0) duty = 0;
    end
    res.applied_speed = 8'(last_speed_m);
    res.forward_drive = (last_speed_m > 0);
    res.reverse_drive = (last_speed_m < 0);
    res.duty          = 8'(duty);
    return res;
  endfunction

  function automatic out_t drive_of(input int speed, input int fwd, input int rev,
                                    input int duty);
    out_t res;
    res.applied_speed = 8'(speed);
    res.forward_drive = 1'(fwd);
    res.reverse_drive = 1'(rev);
    res.duty          = 8'(duty);
    return res;
  endfunction

  // Directed rows: a request with an optional hand-written result, or a
  // register write made once the block has gone quiet.
  task automatic add_req(input logic [15:0] cmd, input logic [31:0] stamp,
                         input bit pinned, input out_t result);
    plan_row_t row;
    row.kind              = ROW_REQ;
    row.reg_idx           = '0;
    row.reg_val           = '0;
    row.req.speed_command = cmd;
    row.req.time_ms       = stamp;
    row.pinned            = pinned;
    row.result            = result;
    directed_plan.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_ADDR_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    row.req     = '0;
    row.pinned  = 1'b0;
    row.result  = '0;
    directed_plan.push_back(row);
  endtask

  // Offer one request; returns at the edge where it was accepted. Random
  // idle cycles go in front so gaps land on every phase of the sequencer.
  task automatic offer_request(input in_t req, input bit pinned, input out_t result);
    pin_entry_t pin;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pin.pinned = pinned;
    pin.result = result;
    pinned_drive_q.push_back(pin);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_drive_q.size() != 0);
  endtask

  // Single-cycle register write; the shadow copy follows the same masking.
  task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DEADBAND: deadband_m = val[6:0];
      REG_RAMP:     ramp_m     = val[6:0];
      REG_MIN_DUTY: min_duty_m = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly commands in the working range, some right at the deadband and
  // clamp edges, some anywhere in the 16-bit range.
  function automatic logic [15:0] pick_command();
    int db;
    db = int'(deadband_m);
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(7))
          0: return 16'(db);
          1: return 16'(-db);
          2: return 16'(db - 1);
          3: return 16'(1 - db);
          4: return 16'(SPEED_LIMIT);
          5: return 16'(-SPEED_LIMIT);
          6: return 16'(SPEED_LIMIT + 1);
          default: return 16'(-SPEED_LIMIT - 1);
        endcase
      end
      default: return 16'($urandom_range(220) - 110);
    endcase
  endfunction

  // Timestamps mostly move a few ms; now and then they repeat, jump far,
  // or land anywhere so the elapsed time wraps.
  function automatic logic [31:0] pick_stamp();
    case ($urandom_range(19))
      0: ;
      1: ms_clock = $urandom;
      2: ms_clock = ms_clock + $urandom_range(100000, 1000);
      default: ms_clock = ms_clock + $urandom_range(60, 1);
    endcase
    return ms_clock;
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // block fills and must stall its input.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Scoreboard: results are checked first, then a request accepted at the
  // same edge gets its prediction queued behind the older ones.
  pin_entry_t pin_now;
  out_t       want_now;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_drive_q.size() == 0) begin
          $error("result with no request outstanding: speed %0d duty %0d",
                 $signed(out_data.applied_speed), out_data.duty);
          mismatch_count++;
        end else begin
          want_now = expected_drive_q.pop_front();
          if (out_data.applied_speed !== want_now.applied_speed) begin
            $error("applied_speed: expected %0d, got %0d",
                   $signed(want_now.applied_speed), $signed(out_data.applied_speed));
            mismatch_count++;
          end
          if (out_data.forward_drive !== want_now.forward_drive) begin
            $error("forward_drive: expected %0b, got %0b",
                   want_now.forward_drive, out_data.forward_drive);
            mismatch_count++;
          end
          if (out_data.reverse_drive !== want_now.reverse_drive) begin
            $error("reverse_drive: expected %0b, got %0b",
                   want_now.reverse_drive, out_data.reverse_drive);
            mismatch_count++;
          end
          if (out_data.duty !== want_now.duty) begin
            $error("duty: expected %0d, got %0d", want_now.duty, out_data.duty);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want_now = shape_command(in_data);
        if (pinned_drive_q.size() != 0) begin
          pin_now = pinned_drive_q.pop_front();
          if (pin_now.pinned) want_now = pin_now.result;
        end
        expected_drive_q.push_back(want_now);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    in_t req;

    // Directed rows start from the reset settings: deadband 10, ramp 5,
    // min duty 40, speed 0 at stamp 0.
    add_req(16'sd0, 32'd0, 1'b1, drive_of(0, 0, 0, 0));         // repeated stamp
    add_req(16'sh7FFF, 32'd20, 1'b0, '0);                        // one period of ramp
    add_req(16'sh7FFF, 32'd4020, 1'b1, drive_of(100, 1, 0, 255));// step saturates
    add_req(16'sh8000, 32'hFFFF_FFFF, 1'b1, drive_of(-100, 0, 1, 255));
    add_req(16'sd5, 32'd16, 1'b0, '0);                           // stamp wraps
    add_req(-16'sd9, 32'd16, 1'b0, '0);                          // same stamp again
    add_req(16'sd10, 32'd2016, 1'b0, '0);                        // exactly deadband
    add_req(16'sd9, 32'd2036, 1'b0, '0);                         // just inside
    add_req(-16'sd10, 32'd4036, 1'b0, '0);
    add_req(16'sd101, 32'd4056, 1'b0, '0);                       // clamped high
    add_req(-16'sd101, 32'd8000, 1'b1, drive_of(-100, 0, 1, 255));
    add_req(16'sd100, 32'd8400, 1'b0, '0);
    add_req(16'sh5555, 32'hAAAA_AAAA, 1'b0, '0);
    add_req(16'shAAAA, 32'h5555_5555, 1'b0, '0);
    // deadband past the clamp zeroes everything
    add_cfg(REG_DEADBAND, 8'd127);
    add_req(16'sh7FFF, 32'h5556_0000, 1'b1, drive_of(0, 0, 0, 0));
    add_cfg(REG_DEADBAND, 8'd0);
    add_cfg(REG_MIN_DUTY, 8'd0);
    add_cfg(REG_RAMP, 8'd127);
    add_req(16'sd1, 32'h5557_0000, 1'b1, drive_of(1, 1, 0, 0));  // moving, zero duty
    add_cfg(REG_MIN_DUTY, 8'd255);
    add_req(-16'sd1, 32'h5558_0000, 1'b1, drive_of(-1, 0, 1, 255));
    // zero ramp still allows a step of one
    add_cfg(REG_RAMP, 8'd0);
    add_req(16'sd100, 32'h5560_0000, 1'b1, drive_of(0, 0, 0, 0));
    add_req(16'sd100, 32'h5560_0000, 1'b1, drive_of(1, 1, 0, 255));
    add_cfg(REG_RAMP, 8'd127);
    add_cfg(REG_MIN_DUTY, 8'd128);
    add_req(-16'sd50, 32'h5560_000A, 1'b0, '0);
    add_cfg(REG_UNUSED, 8'hFF);                                  // dropped write
    add_cfg(REG_DEADBAND, 8'h8A);                                // top bit masked off
    add_cfg(REG_RAMP, 8'h85);
    add_cfg(REG_MIN_DUTY, 8'd40);
    add_req(16'sd0, 32'h5560_0100, 1'b0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 23;
    rx_idle_pct = 60;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        drain_results();
        write_register(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      end else begin
        offer_request(directed_plan[i].req, directed_plan[i].pinned,
                      directed_plan[i].result);
      end
    end
    ms_clock = 32'h5560_0100;

    // Random part: three idle patterns, three register settings each
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 60 : 0;
      rx_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 23 : 0;
      for (int setting = 0; setting < 3; setting++) begin
        drain_results();
        case ($urandom_range(4))
          0:       write_register(REG_DEADBAND, {1'($urandom_range(1)), 7'd0});
          1:       write_register(REG_DEADBAND, {1'($urandom_range(1)), 7'd100});
          2:       write_register(REG_DEADBAND, {1'($urandom_range(1)), 7'd127});
          default: write_register(REG_DEADBAND,
                                  {1'($urandom_range(1)), 7'($urandom_range(25, 1))});
        endcase
        case ($urandom_range(4))
          0:       write_register(REG_RAMP, {1'($urandom_range(1)), 7'd0});
          1:       write_register(REG_RAMP, {1'($urandom_range(1)), 7'd1});
          2:       write_register(REG_RAMP, {1'($urandom_range(1)), 7'd127});
          default: write_register(REG_RAMP,
                                  {1'($urandom_range(1)), 7'($urandom_range(30, 2))});
        endcase
        case ($urandom_range(3))
          0:       write_register(REG_MIN_DUTY, 8'd0);
          1:       write_register(REG_MIN_DUTY, 8'd255);
          default: write_register(REG_MIN_DUTY, 8'($urandom_range(255)));
        endcase
        for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
          // long receiver hold-off while requests keep coming
          if (mode == 0 && setting == 1 && n == 40) rx_hold_req = 1'b1;
          // sender goes quiet until the pipeline is empty
          if (mode == 1 && setting == 2 && n == 60) drain_results();
          req.speed_command = pick_command();
          req.time_ms       = pick_stamp();
          offer_request(req, 1'b0, '0);
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
